[rtl/lphm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and constants of the longest prefix hash match block.
// ----------------------------------------------------------------------------
package lphm_pkg;

   // fixed field widths
   localparam int HASH_W    = 64;
   localparam int IDX_W     = 16;
   localparam int LEN_OUT_W = 8;
   localparam int MIN_W     = 9;

   // beat kinds on the request channel
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ENTRY = 1'b1;

   // control of the sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   // per-cycle command to every cell of the hash chain
   typedef struct packed {
      logic load;     // shift a new hash in at the head, toward the tail
      logic rotate;   // circulate one place toward the head
   } cell_ctl_type;

endpackage

[rtl/longest_prefix_hash_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_hash_match
// Loads a sequence of prefix hashes, then scans each cache entry against it
// and reports the entry with the longest matching prefix on the last entry.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    mode, hash_value, entry_index, last
//  rsp       out        rsp_valid/rsp_ready    found, entry_id, match_len
//  csr       in         csr_wr_en              minimum prefix length (clamped to >= 1)
//
//  A load beat is taken while idle. An entry beat is scanned as the hash
//  ring is rotated once around all SEQ_DEPTH cells, one compare per cycle
//  at the head cell; a last entry then goes to the deliver state to hand off
//  the result. Reset clears the count, the best match and the minimum (to 1);
//  cell contents are not cleared. A held result stalls only the next last entry.
// ----------------------------------------------------------------------------
module longest_prefix_hash_match #(
   parameter int SEQ_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [lphm_pkg::HASH_W-1:0]    req_hash_value,
   input  logic [lphm_pkg::IDX_W-1:0]     req_entry_index,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [lphm_pkg::IDX_W-1:0]     rsp_entry_id,
   output logic [lphm_pkg::LEN_OUT_W-1:0] rsp_match_len,
   input  logic                           csr_wr_en,
   input  logic [lphm_pkg::MIN_W-1:0]     csr_wr_data
);
   import lphm_pkg::*;

   localparam int LW = $clog2(SEQ_DEPTH + 1);
   localparam int SW = $clog2(SEQ_DEPTH);
   localparam int CW = (LW > MIN_W) ? LW : MIN_W;

   state_type             state_ff, state_in;
   logic [LW-1:0]         count_ff, count_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [HASH_W-1:0]     target_ff, target_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  last_ff, last_in;
   logic [LW-1:0]         best_len_ff, best_len_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic                  best_valid_ff, best_valid_in;
   logic [MIN_W-1:0]      min_ff, min_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [LEN_OUT_W-1:0]  rsp_len_ff, rsp_len_in;

   cell_ctl_type          cell_ctl;
   logic [HASH_W-1:0]     head_hash;
   logic                  accept;
   logic [CW-1:0]         cand_len;
   logic                  cand_ok;

   // hash ring
   lphm_chain #(
      .DEPTH (SEQ_DEPTH)
   ) u_chain (
      .clock     (clock),
      .ctl       (cell_ctl),
      .push_hash (req_hash_value),
      .head_hash (head_hash)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // step s shows the hash of prefix length count - s at the head
   assign cand_len = CW'(count_ff) - CW'(step_ff);
   assign cand_ok  = (step_ff != '0) && (CW'(step_ff) < CW'(count_ff))
                     && (cand_len >= CW'(min_ff)) && (head_hash == target_ff)
                     && (cand_len > CW'(best_len_ff));

   // sequencer, best match tracking and result register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      best_len_in   = best_len_ff;
      best_idx_in   = best_idx_ff;
      best_valid_in = best_valid_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_len_in    = rsp_len_ff;
      cell_ctl      = '0;

      if (csr_wr_en) begin
         min_in = (csr_wr_data == '0) ? MIN_W'(1) : csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  // append unless the ring is full
                  if (count_ff != LW'(SEQ_DEPTH)) begin
                     cell_ctl.load = 1'b1;
                     count_in      = count_ff + LW'(1);
                  end
               end else begin
                  target_in = req_hash_value;
                  idx_in    = req_entry_index;
                  last_in   = req_last;
                  step_in   = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cell_ctl.rotate = 1'b1;
            step_in         = step_ff + SW'(1);
            if (cand_ok) begin
               best_len_in   = LW'(cand_len);
               best_idx_in   = idx_ff;
               best_valid_in = 1'b1;
            end
            // one full turn restores the ring
            if (step_ff == SW'(SEQ_DEPTH - 1)) begin
               state_in = last_ff ? ST_DELIVER : ST_IDLE;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = best_valid_ff;
               rsp_idx_in    = best_valid_ff ? best_idx_ff : '0;
               rsp_len_in    = best_valid_ff ? LEN_OUT_W'(best_len_ff) : '0;
               count_in      = '0;
               best_len_in   = '0;
               best_idx_in   = '0;
               best_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         best_len_ff   <= '0;
         best_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
         min_ff        <= MIN_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         best_len_ff   <= best_len_in;
         best_idx_ff   <= best_idx_in;
         best_valid_ff <= best_valid_in;
         min_ff        <= min_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_entry_id  = rsp_idx_ff;
   assign rsp_match_len = rsp_len_ff;

endmodule

[rtl/lphm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_cell
// One stored prefix hash; takes its neighbor's value on a load or a rotate.
// ----------------------------------------------------------------------------
module lphm_cell (
   input  logic                        clock,
   input  lphm_pkg::cell_ctl_type      ctl,
   input  logic [lphm_pkg::HASH_W-1:0] load_in,
   input  logic [lphm_pkg::HASH_W-1:0] rotate_in,
   output logic [lphm_pkg::HASH_W-1:0] hash_out
);
   import lphm_pkg::*;

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;

   // load shifts away from the head, rotate moves toward it
   always_comb begin
      hash_in = hash_ff;
      if (ctl.load) begin
         hash_in = load_in;
      end else if (ctl.rotate) begin
         hash_in = rotate_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign hash_out = hash_ff;

endmodule

[rtl/lphm_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_chain
// Row of hash cells: newest hash at the head, the row closes into a ring.
// ----------------------------------------------------------------------------
module lphm_chain #(
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  lphm_pkg::cell_ctl_type      ctl,
   input  logic [lphm_pkg::HASH_W-1:0] push_hash,
   output logic [lphm_pkg::HASH_W-1:0] head_hash
);
   import lphm_pkg::*;

   logic [HASH_W-1:0] cell_hash [DEPTH];

   // cell k loads from k-1 (head from the port) and rotates from k+1 mod depth
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam int NextK = (k + 1) % DEPTH;
      localparam int PrevK = (k == 0) ? 0 : k - 1;
      logic [HASH_W-1:0] load_src;

      if (k == 0) begin : g_head
         assign load_src = push_hash;
      end else begin : g_body
         assign load_src = cell_hash[PrevK];
      end

      lphm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_in   (load_src),
         .rotate_in (cell_hash[NextK]),
         .hash_out  (cell_hash[k])
      );
   end

   assign head_hash = cell_hash[0];

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for longest_prefix_hash_match. A behavioral predictor
// tracks the loaded prefix hashes and the best match of the open query, and
// every result beat is compared field by field against it. Directed queries
// cover the corner cases; random queries then run under several idle and
// stall mixes and several minimum-length settings.
// ----------------------------------------------------------------------------
module testbench;
   import lphm_pkg::*;

   localparam int SEQ_DEPTH    = 256;
   // one entry scan plus hand-off, with margin
   localparam int DRAIN_CYCLES = SEQ_DEPTH + 16;

   typedef struct packed {
      logic                 mode;
      logic [HASH_W-1:0]    hash_value;
      logic [IDX_W-1:0]     entry_index;
      logic                 last;
   } req_beat_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_W-1:0]     entry_id;
      logic [LEN_OUT_W-1:0] match_len;
   } match_type;

   // block ports
   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic                 req_mode        = MODE_LOAD;
   logic [HASH_W-1:0]    req_hash_value  = '0;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic                 req_last        = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic                 rsp_found;
   logic [IDX_W-1:0]     rsp_entry_id;
   logic [LEN_OUT_W-1:0] rsp_match_len;
   logic                 csr_wr_en       = 1'b0;
   logic [MIN_W-1:0]     csr_wr_data     = '0;

   // predictor state
   logic [HASH_W-1:0]    seq_store [SEQ_DEPTH];
   int unsigned          seq_count   = 0;
   int unsigned          best_len    = 0;
   logic [IDX_W-1:0]     best_index  = '0;
   logic                 best_hit    = 1'b0;
   logic [MIN_W-1:0]     min_len_reg = 9'd1;

   // beats waiting to be driven, results waiting to arrive
   req_beat_type         pending_beats [$];
   match_type            expected_matches [$];

   bit                   req_fired      = 1'b0;
   int unsigned          beats_sent     = 0;
   int unsigned          beats_accepted = 0;
   int unsigned          send_idle_pct  = 0;
   int unsigned          rsp_stall_pct  = 0;
   int unsigned          n_loads        = 0;
   int unsigned          n_entries      = 0;
   int unsigned          n_dropped      = 0;
   int unsigned          n_results      = 0;
   int unsigned          n_hits         = 0;
   int unsigned          n_errors       = 0;

   longest_prefix_hash_match #(
      .SEQ_DEPTH(SEQ_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_hash_value (req_hash_value),
      .req_entry_index(req_entry_index),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_entry_id   (rsp_entry_id),
      .rsp_match_len  (rsp_match_len),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // longest matching prefix from the minimum up, last stored hash excluded, 0 if none
   function automatic int unsigned longest_prefix(input logic [HASH_W-1:0] target);
      int lo;
      lo = (min_len_reg == '0) ? 1 : int'(min_len_reg);
      for (int len = int'(seq_count) - 1; len >= lo; len--) begin
         if (seq_store[len - 1] == target) return len;
      end
      return 0;
   endfunction

   // advance the predictor by one accepted request beat
   function automatic void apply_beat(input logic mode, input logic [HASH_W-1:0] hash,
                                      input logic [IDX_W-1:0] index, input logic last);
      int unsigned len;
      match_type   m;
      if (mode == MODE_LOAD) begin
         n_loads++;
         if (seq_count < SEQ_DEPTH) begin
            seq_store[seq_count] = hash;
            seq_count++;
         end else begin
            n_dropped++;
         end
         return;
      end
      n_entries++;
      len = longest_prefix(hash);
      if (len > 0 && len > best_len) begin
         best_len   = len;
         best_index = index;
         best_hit   = 1'b1;
      end
      if (last) begin
         m.found     = best_hit;
         m.entry_id  = best_hit ? best_index : '0;
         m.match_len = best_hit ? LEN_OUT_W'(best_len) : '0;
         expected_matches = {expected_matches, m};
         seq_count  = 0;
         best_len   = 0;
         best_index = '0;
         best_hit   = 1'b0;
      end
   endfunction

   function automatic logic [HASH_W-1:0] random_hash();
      return {$urandom, $urandom};
   endfunction

   // request beats accepted at this edge
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_fired = 1'b1;
         apply_beat(req_mode, req_hash_value, req_entry_index, req_last);
         beats_accepted++;
      end
   end

   // request driver: hold the beat until taken, idle at random between beats
   always @(negedge clock) begin : drive_req
      req_beat_type b;
      if (!req_valid || req_fired) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            b = pending_beats.pop_front();
            req_valid       <= 1'b1;
            req_mode        <= b.mode;
            req_hash_value  <= b.hash_value;
            req_entry_index <= b.entry_index;
            req_last        <= b.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // compare each result beat with the oldest expected match
   always @(posedge clock) begin : check_rsp
      match_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $error("unexpected result: rsp_found=%0d rsp_entry_id=%0d rsp_match_len=%0d",
                   rsp_found, rsp_entry_id, rsp_match_len);
            n_errors++;
         end else begin
            want = expected_matches.pop_front();
            n_results++;
            if (want.found) n_hits++;
            if (rsp_found !== want.found) begin
               $error("rsp_found: expected %0d, got %0d", want.found, rsp_found);
               n_errors++;
            end
            if (rsp_entry_id !== want.entry_id) begin
               $error("rsp_entry_id: expected %0d, got %0d",
                      want.entry_id, rsp_entry_id);
               n_errors++;
            end
            if (rsp_match_len !== want.match_len) begin
               $error("rsp_match_len: expected %0d, got %0d",
                      want.match_len, rsp_match_len);
               n_errors++;
            end
         end
      end
   end

   // queue one request beat and wait until the block takes it
   task automatic send_beat(input logic mode, input logic [HASH_W-1:0] hash,
                            input logic [IDX_W-1:0] index, input logic last);
      req_beat_type b;
      b.mode        = mode;
      b.hash_value  = hash;
      b.entry_index = index;
      b.last        = last;
      pending_beats = {pending_beats, b};
      beats_sent++;
      wait (beats_accepted >= beats_sent);
   endtask

   // hold off until every queued beat is taken and every result has arrived
   task automatic wait_results_drained();
      while (pending_beats.size() != 0 || beats_accepted < beats_sent ||
             expected_matches.size() != 0)
         @(posedge clock);
   endtask

   // change the minimum only once the block has gone quiet
   task automatic write_min_len(input int unsigned value);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= MIN_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      min_len_reg = MIN_W'(value);
   endtask

   // longest match wins, last stored hash is out of reach, extreme field values
   task automatic test_basic_match();
      write_min_len(1);
      send_beat(MODE_LOAD, 64'h0000_0000_0000_0000, 16'h0000, 1'b1);
      send_beat(MODE_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
      send_beat(MODE_LOAD, 64'h0123_4567_89AB_CDEF, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'hA5A5_A5A5_A5A5_A5A5, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'h5A5A_5A5A_5A5A_5A5A, 16'h0000, 1'b0);
      send_beat(MODE_ENTRY, 64'h0123_4567_89AB_CDEF, 16'hFFFF, 1'b0);
      send_beat(MODE_ENTRY, 64'h5A5A_5A5A_5A5A_5A5A, 16'h0001, 1'b0);
      send_beat(MODE_ENTRY, 64'h0000_0000_0000_0000, 16'h0000, 1'b1);
   endtask

   // equal lengths keep the earlier entry; a load inside a query appends
   task automatic test_tie_and_late_load();
      send_beat(MODE_LOAD, 64'hDEAD_BEEF_0000_0001, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'hDEAD_BEEF_0000_0002, 16'h0000, 1'b0);
      send_beat(MODE_ENTRY, 64'hDEAD_BEEF_0000_0001, 16'h0007, 1'b0);
      send_beat(MODE_ENTRY, 64'hDEAD_BEEF_0000_0001, 16'h0009, 1'b0);
      send_beat(MODE_LOAD, 64'hDEAD_BEEF_0000_0003, 16'hFFFF, 1'b1);
      send_beat(MODE_ENTRY, 64'hDEAD_BEEF_0000_0002, 16'h0003, 1'b1);
   endtask

   // empty store, sequence shorter than the minimum, minimum of zero clamped
   task automatic test_short_and_clamp();
      send_beat(MODE_ENTRY, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
      write_min_len(4);
      send_beat(MODE_LOAD, 64'h1111_1111_1111_1111, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'h2222_2222_2222_2222, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'h3333_3333_3333_3333, 16'h0000, 1'b0);
      send_beat(MODE_ENTRY, 64'h1111_1111_1111_1111, 16'h00AA, 1'b1);
      write_min_len(0);
      send_beat(MODE_LOAD, 64'h1111_1111_1111_1111, 16'h0000, 1'b0);
      send_beat(MODE_LOAD, 64'h2222_2222_2222_2222, 16'h0000, 1'b0);
      send_beat(MODE_ENTRY, 64'h1111_1111_1111_1111, 16'h0055, 1'b1);
   endtask

   // overfill the store, longest reportable prefix, then a minimum of the full depth
   task automatic test_store_full();
      logic [HASH_W-1:0] dropped;
      write_min_len(1);
      for (int i = 0; i < SEQ_DEPTH + 4; i++) begin
         dropped = random_hash();
         send_beat(MODE_LOAD, dropped, IDX_W'($urandom), 1'($urandom));
      end
      send_beat(MODE_ENTRY, dropped, IDX_W'($urandom), 1'b0);
      send_beat(MODE_ENTRY, seq_store[SEQ_DEPTH - 2], IDX_W'($urandom), 1'b0);
      send_beat(MODE_ENTRY, seq_store[SEQ_DEPTH - 1], IDX_W'($urandom), 1'b1);
      write_min_len(SEQ_DEPTH);
      for (int i = 0; i < SEQ_DEPTH; i++)
         send_beat(MODE_LOAD, random_hash(), IDX_W'($urandom), 1'b0);
      send_beat(MODE_ENTRY, seq_store[SEQ_DEPTH - 2], IDX_W'($urandom), 1'b0);
      send_beat(MODE_ENTRY, seq_store[0], 16'hFFFF, 1'b1);
   endtask

   // one query: loads, then entries aimed mostly at stored hashes
   task automatic send_random_query();
      logic [HASH_W-1:0] pool [3];
      logic [HASH_W-1:0] target;
      logic              narrow;
      logic              last_flag;
      int unsigned       n_load;
      int unsigned       n_entry;
      int unsigned       pick;
      for (int i = 0; i < 3; i++) pool[i] = random_hash();
      // a few repeated hashes make several lengths match at once
      narrow = 1'($urandom_range(1));
      if ($urandom_range(24) == 0) n_load = $urandom_range(SEQ_DEPTH - 6, SEQ_DEPTH + 14);
      else n_load = $urandom_range(0, 20);
      n_entry = $urandom_range(1, 4);
      for (int i = 0; i < n_load; i++) begin
         send_beat(MODE_LOAD, narrow ? pool[$urandom_range(2)] : random_hash(),
                   IDX_W'($urandom), 1'($urandom_range(1)));
      end
      for (int e = 0; e < n_entry; e++) begin
         if ($urandom_range(9) == 0)
            send_beat(MODE_LOAD, random_hash(), IDX_W'($urandom), 1'($urandom_range(1)));
         pick = $urandom_range(9);
         if (pick < 7 && seq_count > 0) target = seq_store[$urandom_range(seq_count - 1)];
         else if (pick < 9) target = pool[$urandom_range(2)];
         else target = random_hash();
         // now and then the query is left open and runs into the next one
         last_flag = (e == n_entry - 1) && ($urandom_range(19) != 0);
         send_beat(MODE_ENTRY, target, IDX_W'($urandom), last_flag);
      end
   endtask

   task automatic run_random_phase(input int unsigned beats, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      int unsigned start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         // sometimes the sender waits for every result before going on
         if ($urandom_range(9) == 0) wait_results_drained();
         send_random_query();
      end
   endtask

   // random queries under each idle mix and several minimum settings
   task automatic test_random_queries();
      write_min_len(1);
      run_random_phase(340, 0, 0);
      write_min_len($urandom_range(2, 6));
      run_random_phase(340, 84, 0);
      write_min_len($urandom_range(1, 3));
      run_random_phase(340, 0, 84);
      write_min_len(0);
      run_random_phase(340, 27, 27);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_match();
      test_tie_and_late_load();
      test_short_and_clamp();
      test_store_full();
      test_random_queries();

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_matches.size() != 0) begin
         $error("%0d expected results never arrived", expected_matches.size());
         n_errors++;
      end
      $display("covered %0d loads (%0d dropped on a full store) and %0d cache entries",
               n_loads, n_dropped, n_entries);
      $display("checked %0d query results, %0d with a match, %0d mismatches",
               n_results, n_hits, n_errors);
      if (n_errors == 0) begin
         $display("longest_prefix_hash_match regression: pass");
      end else begin
         $display("longest_prefix_hash_match regression: fail");
      end
      $finish;
   end

   // hang guard
   initial begin
      #20_000_000;
      $display("longest_prefix_hash_match regression: fail");
      $finish;
   end

endmodule

[longest_prefix_hash_match.f]
rtl/lphm_pkg.sv
rtl/lphm_cell.sv
rtl/lphm_chain.sv
rtl/longest_prefix_hash_match.sv
tb/testbench.sv
